// ===== design/conv3_pkg.sv =====
// ----------------------------------------------------------------------------
// conv3_pkg
// Shared widths, register indexes and types of the 3x3 gray filter core.
// ----------------------------------------------------------------------------
`default_nettype none

package conv3_pkg;

    localparam int MAX_WIDTH      = 1024;
    localparam int ADDR_W         = $clog2(MAX_WIDTH);
    localparam int WIDTH_REG_W    = 11;
    localparam int HEIGHT_W       = 16;
    localparam int COEF_ROW_W     = 54;
    localparam int COEF_W         = 18;
    localparam int COEF_FRAC_BITS = 12;
    localparam int PIX_W          = 8;
    localparam int PROD_W         = PIX_W + 1 + COEF_W;
    localparam int PART_W         = PROD_W + 2;
    localparam int SUM_W          = PART_W + 2;
    localparam int CFG_IDX_W      = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_TOP     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_MID     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_BOT     = 3'd4;

    localparam logic [WIDTH_REG_W-1:0] WIDTH_RESET  = 11'd640;
    localparam logic [HEIGHT_W-1:0]    HEIGHT_RESET = 16'd480;
    // identity kernel: middle coefficient of the middle row is 1.0
    localparam logic [COEF_ROW_W-1:0]  COEF_MID_RESET =
        COEF_ROW_W'(64'd1 << (COEF_W + COEF_FRAC_BITS));

    typedef logic [PIX_W-1:0] pix_t;
    // one window column: [0] top, [1] middle, [2] bottom
    typedef logic [2:0][PIX_W-1:0] col_t;
    // coefficients of one window column, same row order
    typedef logic [2:0][COEF_W-1:0] coef_col_t;
    typedef logic signed [PART_W-1:0] part_t;

    // per-item decision from the counter unit
    typedef struct packed {
        logic              wr;
        logic [ADDR_W-1:0] addr;
        logic              emit;
        logic              interior;
        logic              last;
    } ctrl_t;

    // pipeline token that travels beside the data
    typedef struct packed {
        logic valid;
        logic wr;
        logic interior;
        logic last;
    } tok_t;

endpackage

`default_nettype wire

// ===== design/conv3x3_gray_filter_core.sv =====
// ----------------------------------------------------------------------------
// conv3x3_gray_filter_core
// Streaming 3x3 convolution of 8-bit gray pixels with Q6.12 coefficients,
// rounded half to even and clamped to 0..255; border pixels give 0.
// ----------------------------------------------------------------------------
// Throughput: one item per clock; the whole pipeline stalls only while a
//   result sits in the output register and m_tready is low.
// Pipeline: an item that is taken passes the line store read, window shift,
//   column products, column sums and round, in that order, to its result.
// Reset (aresetn low, synchronous): counters, pipeline, window and registers
//   return to defaults; the line store is not cleared.
`default_nettype none

module conv3x3_gray_filter_core (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // configuration
    input  wire logic                                cfg_we,
    input  wire logic [conv3_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [conv3_pkg::COEF_ROW_W-1:0]    cfg_wdata,
    // input items
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [7:0]                          s_tdata,   // pixel_in
    input  wire logic [0:0]                          s_tuser,   // func
    // result items
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [7:0]                               m_tdata,   // pixel_out
    output logic [0:0]                               m_tuser,   // clipped
    output logic                                     m_tlast
);

    localparam int PW = conv3_pkg::PIX_W;
    localparam int CW = conv3_pkg::COEF_W;
    localparam int SW = conv3_pkg::SUM_W;
    localparam int FB = conv3_pkg::COEF_FRAC_BITS;
    localparam int QW = SW - FB + 1;

    logic [conv3_pkg::WIDTH_REG_W-1:0] width_reg;
    logic [conv3_pkg::HEIGHT_W-1:0]    height_reg;
    logic [conv3_pkg::COEF_ROW_W-1:0]  coef_top_reg, coef_mid_reg, coef_bot_reg;

    logic                              en;
    logic                              accept;
    conv3_pkg::ctrl_t                  info;
    conv3_pkg::tok_t                   tok1_reg, tok2_reg, tok3_reg, tok4_reg;
    logic [conv3_pkg::ADDR_W-1:0]      s1_addr_reg;
    conv3_pkg::pix_t                   s1_px_reg;
    logic [2*PW-1:0]                   pair;
    conv3_pkg::col_t                   new_col;
    conv3_pkg::col_t                   cell_out [3];
    conv3_pkg::coef_col_t              coef_cols [3];
    conv3_pkg::part_t                  parts [3];

    logic signed [SW-1:0]              total;
    logic signed [QW-1:0]              q;
    logic [FB-1:0]                     rem;
    logic                              round_up;
    logic signed [QW-1:0]              rounded;
    logic [PW-1:0]                     val;
    logic                              clip;

    logic                              m_tvalid_reg;
    logic [PW-1:0]                     m_tdata_reg;
    logic                              m_tuser_reg;
    logic                              m_tlast_reg;

    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;
    assign accept   = s_tvalid && en;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg    <= conv3_pkg::WIDTH_RESET;
            height_reg   <= conv3_pkg::HEIGHT_RESET;
            coef_top_reg <= '0;
            coef_mid_reg <= conv3_pkg::COEF_MID_RESET;
            coef_bot_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                conv3_pkg::REG_IMAGE_WIDTH:
                    width_reg <= cfg_wdata[conv3_pkg::WIDTH_REG_W-1:0];
                conv3_pkg::REG_IMAGE_HEIGHT:
                    height_reg <= cfg_wdata[conv3_pkg::HEIGHT_W-1:0];
                conv3_pkg::REG_COEF_TOP: coef_top_reg <= cfg_wdata;
                conv3_pkg::REG_COEF_MID: coef_mid_reg <= cfg_wdata;
                conv3_pkg::REG_COEF_BOT: coef_bot_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    conv3_ctrl u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .accept       (accept),
        .func         (s_tuser[0]),
        .image_width  (width_reg),
        .image_height (height_reg),
        .info         (info)
    );

    conv3_linebuf u_linebuf (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .rd_addr (info.addr),
        .wr_en   (tok1_reg.wr),
        .wr_addr (s1_addr_reg),
        .wr_data ({pair[PW-1:0], s1_px_reg}),
        .rd_data (pair)
    );

    // pipeline tokens
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok1_reg <= '0;
            tok2_reg <= '0;
            tok3_reg <= '0;
            tok4_reg <= '0;
        end else if (en) begin
            tok1_reg.valid    <= accept && info.emit;
            tok1_reg.wr       <= accept && info.wr;
            tok1_reg.interior <= info.interior;
            tok1_reg.last     <= info.last;
            tok2_reg          <= tok1_reg;
            tok3_reg          <= tok2_reg;
            tok4_reg          <= tok3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_addr_reg <= info.addr;
            s1_px_reg   <= s_tdata;
        end
    end

    // new right column: upper row, lower row, incoming pixel
    assign new_col[0] = pair[2*PW-1:PW];
    assign new_col[1] = pair[PW-1:0];
    assign new_col[2] = s1_px_reg;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            coef_cols[k][0] = coef_top_reg[k*CW +: CW];
            coef_cols[k][1] = coef_mid_reg[k*CW +: CW];
            coef_cols[k][2] = coef_bot_reg[k*CW +: CW];
        end
    end

    // cell 2 is the right column, pixels move leftward to cell 0
    for (genvar k = 0; k < 3; k++) begin : g_cell
        conv3_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .shift   (tok1_reg.wr),
            .col_in  ((k == 2) ? new_col : cell_out[(k + 1) % 3]),
            .coef    (coef_cols[k]),
            .col_out (cell_out[k]),
            .part    (parts[k])
        );
    end

    // round half to even, then clamp
    always_comb begin
        total    = SW'(parts[0]) + SW'(parts[1]) + SW'(parts[2]);
        q        = QW'(total >>> FB);
        rem      = total[FB-1:0];
        round_up = (rem > (FB'(1) << (FB - 1)))
                || ((rem == (FB'(1) << (FB - 1))) && q[0]);
        rounded  = q + QW'(round_up);
        if (rounded < 0) begin
            val  = '0;
            clip = 1'b1;
        end else if (rounded > QW'(255)) begin
            val  = 8'hFF;
            clip = 1'b1;
        end else begin
            val  = rounded[PW-1:0];
            clip = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= tok4_reg.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_tdata_reg <= tok4_reg.interior ? val : '0;
            m_tuser_reg <= tok4_reg.interior && clip;
            m_tlast_reg <= tok4_reg.last;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;
    assign m_tlast    = m_tlast_reg;

endmodule

`default_nettype wire

// ===== design/conv3_linebuf.sv =====
// ----------------------------------------------------------------------------
// conv3_linebuf
// Two-row line store, one entry per column holding the upper and lower row.
// ----------------------------------------------------------------------------
`default_nettype none

module conv3_linebuf (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        en,
    input  wire logic [conv3_pkg::ADDR_W-1:0]  rd_addr,
    input  wire logic                        wr_en,
    input  wire logic [conv3_pkg::ADDR_W-1:0]  wr_addr,
    input  wire logic [2*conv3_pkg::PIX_W-1:0] wr_data,
    output logic      [2*conv3_pkg::PIX_W-1:0] rd_data
);

    logic [2*conv3_pkg::PIX_W-1:0] mem [conv3_pkg::MAX_WIDTH];
    logic [2*conv3_pkg::PIX_W-1:0] rd_q_reg;
    logic [2*conv3_pkg::PIX_W-1:0] fwd_data_reg;
    logic                          fwd_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            if (wr_en) begin
                mem[wr_addr] <= wr_data;
            end
            rd_q_reg     <= mem[rd_addr];
            fwd_data_reg <= wr_data;
        end
    end

    // a read of the column being written in the same cycle takes the new entry
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_reg <= 1'b0;
        end else if (en) begin
            fwd_reg <= wr_en && (wr_addr == rd_addr);
        end
    end

    assign rd_data = fwd_reg ? fwd_data_reg : rd_q_reg;

endmodule

`default_nettype wire

// ===== design/conv3_cell.sv =====
// ----------------------------------------------------------------------------
// conv3_cell
// One window column: holds three pixels, passes them to its neighbor and
// forms the weighted sum of the column.
// ----------------------------------------------------------------------------
`default_nettype none

module conv3_cell (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 en,
    input  wire logic                 shift,
    input  wire conv3_pkg::col_t      col_in,
    input  wire conv3_pkg::coef_col_t coef,
    output conv3_pkg::col_t           col_out,
    output conv3_pkg::part_t          part
);

    conv3_pkg::col_t                       pix_reg;
    logic signed [conv3_pkg::PROD_W-1:0]   prod_reg [3];
    conv3_pkg::part_t                      part_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pix_reg <= '0;
        end else if (en && shift) begin
            pix_reg <= col_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                prod_reg[i] <= $signed({1'b0, pix_reg[i]}) * $signed(coef[i]);
            end
            part_reg <= conv3_pkg::PART_W'(prod_reg[0])
                      + conv3_pkg::PART_W'(prod_reg[1])
                      + conv3_pkg::PART_W'(prod_reg[2]);
        end
    end

    assign col_out = pix_reg;
    assign part    = part_reg;

endmodule

`default_nettype wire

// ===== design/conv3_ctrl.sv =====
// ----------------------------------------------------------------------------
// conv3_ctrl
// Input and output position counters; decides per item whether it is
// stored, whether it gives a result and where that result lies.
// ----------------------------------------------------------------------------
`default_nettype none

module conv3_ctrl (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              accept,
    input  wire logic                              func,
    input  wire logic [conv3_pkg::WIDTH_REG_W-1:0] image_width,
    input  wire logic [conv3_pkg::HEIGHT_W-1:0]    image_height,
    output conv3_pkg::ctrl_t                       info
);

    localparam int AW = conv3_pkg::ADDR_W;
    localparam int WW = conv3_pkg::WIDTH_REG_W;
    localparam int HW = conv3_pkg::HEIGHT_W;

    logic [AW-1:0] in_col_reg,  in_col_next;
    logic [HW-1:0] in_row_reg,  in_row_next;
    logic [AW-1:0] out_col_reg, out_col_next;
    logic [HW-1:0] out_row_reg, out_row_next;

    logic [WW-1:0] w_eff;
    logic [HW-1:0] h_eff;
    logic          restart;
    logic [AW-1:0] ic, oc;
    logic [HW-1:0] ir, orow;
    logic          pix;
    logic          emit;
    logic          result;
    logic          ic_wrap, oc_wrap, or_last;

    always_comb begin
        if (image_width == '0) begin
            w_eff = WW'(1);
        end else if (image_width > WW'(conv3_pkg::MAX_WIDTH)) begin
            w_eff = WW'(conv3_pkg::MAX_WIDTH);
        end else begin
            w_eff = image_width;
        end
        h_eff = (image_height == '0) ? HW'(1) : image_height;

        // image fully delivered: start over
        restart = (in_row_reg >= h_eff) && (out_row_reg >= h_eff);
        ic   = restart ? '0 : in_col_reg;
        ir   = restart ? '0 : in_row_reg;
        oc   = restart ? '0 : out_col_reg;
        orow = restart ? '0 : out_row_reg;

        pix     = !func && (ir < h_eff);
        ic_wrap = (WW'(ic) + WW'(1)) >= w_eff;
        oc_wrap = (WW'(oc) + WW'(1)) >= w_eff;
        or_last = ({1'b0, orow} + (HW+1)'(1)) >= {1'b0, h_eff};

        in_col_next = ic;
        in_row_next = ir;
        if (pix) begin
            // one row and one pixel in before the first result
            emit = (ir >= HW'(2)) || ((ir == HW'(1)) && (ic != '0))
                || ((ir == '0) && (WW'(ic) >= (w_eff + WW'(1))));
            in_col_next = ic_wrap ? '0 : ic + AW'(1);
            in_row_next = ic_wrap ? ir + HW'(1) : ir;
        end else begin
            emit = ir >= h_eff;
        end

        result       = emit && (orow < h_eff);
        out_col_next = oc;
        out_row_next = orow;
        if (result) begin
            out_col_next = oc_wrap ? '0 : oc + AW'(1);
            out_row_next = oc_wrap ? orow + HW'(1) : orow;
            if (oc_wrap && or_last) begin
                in_col_next  = '0;
                in_row_next  = '0;
                out_col_next = '0;
                out_row_next = '0;
            end
        end

        info.wr       = pix;
        info.addr     = ic;
        info.emit     = result;
        info.interior = (orow != '0) && !or_last && (oc != '0) && !oc_wrap;
        info.last     = or_last && oc_wrap;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end else if (accept) begin
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/conv3_checker.sv =====
// ----------------------------------------------------------------------------
// conv3_checker
// Port-level checks of the 3x3 gray filter core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module conv3_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_tready,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata,
    input wire logic [0:0] m_tuser,
    input wire logic       m_tlast
);

    // a stalled result stays offered
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result item dropped while stalled");

    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=>
            $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
        else $error("result item changed while stalled");

    // a clamped result sits at one end of the range
    a_clip_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> (m_tdata == 8'h00) || (m_tdata == 8'hFF))
        else $error("clipped flag on an unclamped pixel");

    // input side waits only on a blocked result
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("input not ready without a blocked result");

endmodule

bind conv3x3_gray_filter_core conv3_checker u_conv3_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire
